>>> design/streaming_substring_remover_unit_macros.svh
// Assertion macros for the substring remover.
// Empty bodies when SYNTHESIS is defined.
`ifndef STREAMING_SUBSTRING_REMOVER_UNIT_MACROS_SVH
`define STREAMING_SUBSTRING_REMOVER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssr assertion failed");
// Next-cycle implication.
`define SSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssr assertion failed");
`else
`define SSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/ssr_pkg.sv
package ssr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 4;   // holds 0..PATTERN_MAX
  localparam int IDX_W       = 3;   // indexes PATTERN_MAX entries
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  // Results caused by one input byte: the first 'count' entries of 'bytes',
  // or a single empty terminator when 'term' is set. 'last' marks end of text.
  typedef struct packed {
    byte_t [PATTERN_MAX-1:0] bytes;
    logic  [CNT_W-1:0]       count;
    logic                    term;
    logic                    last;
  } burst_t;

  // Length register clamped to 1..PATTERN_MAX
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [CNT_W-1:0] n;
    n = CNT_W'(raw);
    if (n == '0) begin
      n = CNT_W'(1);
    end
    if (n > CNT_W'(PATTERN_MAX)) begin
      n = CNT_W'(PATTERN_MAX);
    end
    return n;
  endfunction

endpackage

>>> design/ssr_window.sv
// Lookahead window, pattern registers and the per-byte match decision.
module ssr_window import ssr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  byte_t                 char_i,
  input  logic                  end_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output burst_t                burst_o
);

  byte_t [PATTERN_MAX-1:0] pattern_q;
  logic  [LEN_W-1:0]       length_q;
  byte_t                   win_q [PATTERN_MAX];
  byte_t                   win_d [PATTERN_MAX];
  logic  [CNT_W-1:0]       cnt_q, cnt_d;

  byte_t [PATTERN_MAX-1:0] comb;
  logic  [CNT_W-1:0]       len, fill, start, emit;
  logic  [IDX_W-1:0]       start_idx;
  logic  [PATTERN_MAX-1:0] mismatch;
  logic                    full, matched;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATTERN_BYTES:  pattern_q <= cfg_data_i;
        REG_PATTERN_LENGTH: length_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window plus the new byte, oldest first
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      comb[j] = (CNT_W'(j) < cnt_q) ? win_q[j] : char_i;
    end
  end

  assign len       = eff_len(length_q);
  assign fill      = cnt_q + CNT_W'(1);
  assign full      = (fill >= len);
  assign start     = fill - len;
  assign start_idx = start[IDX_W-1:0];

  // Compare the newest len bytes against the pattern
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      mismatch[i] = (CNT_W'(i) < len) &&
                    (comb[IDX_W'(start_idx + IDX_W'(i))] != pattern_q[i]);
    end
  end

  assign matched = full && (mismatch == '0);

  // Number of bytes leaving the window for this step
  always_comb begin
    if (end_i) begin
      emit = matched ? start : fill;
    end else if (!full) begin
      emit = '0;
    end else if (matched) begin
      emit = start;
    end else begin
      emit = start + CNT_W'(1);
    end
  end

  // Remaining bytes shift down by the emitted count
  always_comb begin
    cnt_d = (end_i || matched) ? '0 : (fill - emit);
    for (int j = 0; j < PATTERN_MAX; j++) begin
      win_d[j] = comb[IDX_W'(IDX_W'(j) + emit[IDX_W-1:0])];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  assign burst_o.bytes = comb;
  assign burst_o.term  = end_i && (emit == '0);
  assign burst_o.count = (end_i && (emit == '0)) ? CNT_W'(1) : emit;
  assign burst_o.last  = end_i;

endmodule

>>> design/streaming_substring_remover_unit.sv
// Output: a byte pushed out of the lookahead window goes to the output register or
//   is queued (the window delays text by up to pattern length - 1 bytes).
// Throughput: one byte per cycle while each byte causes at most one result and the
//   output is ready; extra results (end-of-text flush, shrunk length) stall input.
// Reset: window empty, no pending results, pattern zero and pattern length one.
//   Window byte storage is not reset.
`include "streaming_substring_remover_unit_macros.svh"

module streaming_substring_remover_unit import ssr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] char_in
  input  logic                  s_axis_tlast,   // end_of_text
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] char_out
  output logic                  m_axis_tuser,   // [0] char_present
  output logic                  m_axis_tlast,   // last_out
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  burst_t                  burst;
  logic                    accept, out_free, direct, pop;

  byte_t [PATTERN_MAX-1:0] bq_bytes_q, bq_bytes_d;
  logic  [CNT_W-1:0]       bq_n_q, bq_n_d;
  logic  [IDX_W-1:0]       bq_ptr_q, bq_ptr_d;
  logic                    bq_term_q, bq_term_d;
  logic                    bq_last_q, bq_last_d;

  logic                    out_valid_q, out_valid_d;
  byte_t                   out_char_q, out_char_d;
  logic                    out_present_q, out_present_d;
  logic                    out_last_q, out_last_d;

  ssr_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .char_i      (s_axis_tdata),
    .end_i       (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .burst_o     (burst)
  );

  // Input taken only when no earlier results are queued
  assign s_axis_tready = (bq_n_q == '0);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign direct        = accept && (burst.count != '0) && out_free;
  assign pop           = (bq_n_q != '0) && out_free;

  // Result queue: first result may go straight to the output register
  always_comb begin
    bq_bytes_d = bq_bytes_q;
    bq_n_d     = bq_n_q;
    bq_ptr_d   = bq_ptr_q;
    bq_term_d  = bq_term_q;
    bq_last_d  = bq_last_q;
    if (accept) begin
      bq_bytes_d = burst.bytes;
      bq_term_d  = burst.term;
      bq_last_d  = burst.last;
      if (direct) begin
        bq_n_d   = burst.count - CNT_W'(1);
        bq_ptr_d = IDX_W'(1);
      end else begin
        bq_n_d   = burst.count;
        bq_ptr_d = '0;
      end
    end else if (pop) begin
      bq_n_d   = bq_n_q - CNT_W'(1);
      bq_ptr_d = bq_ptr_q + IDX_W'(1);
    end
  end

  // Output register; terminator carries a zero byte
  always_comb begin
    out_valid_d   = out_valid_q;
    out_char_d    = out_char_q;
    out_present_d = out_present_q;
    out_last_d    = out_last_q;
    if (direct) begin
      out_valid_d   = 1'b1;
      out_char_d    = burst.term ? '0 : burst.bytes[0];
      out_present_d = !burst.term;
      out_last_d    = burst.last && (burst.count == CNT_W'(1));
    end else if (pop) begin
      out_valid_d   = 1'b1;
      out_char_d    = bq_term_q ? '0 : bq_bytes_q[bq_ptr_q];
      out_present_d = !bq_term_q;
      out_last_d    = bq_last_q && (bq_n_q == CNT_W'(1));
    end else if (m_axis_tready) begin
      out_valid_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bq_n_q      <= '0;
      bq_ptr_q    <= '0;
      bq_term_q   <= 1'b0;
      bq_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bq_n_q      <= bq_n_d;
      bq_ptr_q    <= bq_ptr_d;
      bq_term_q   <= bq_term_d;
      bq_last_q   <= bq_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bq_bytes_q    <= bq_bytes_d;
    out_char_q    <= out_char_d;
    out_present_q <= out_present_d;
    out_last_q    <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_present_q;
  assign m_axis_tlast  = out_last_q;

  // Empty terminator only ever closes a text
  `SSR_ASSERT_IMP(a_term_is_last, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
  // Queued results keep the output busy
  `SSR_ASSERT_NXT(a_queue_feeds_out, clk_i, rst_ni, bq_n_q != '0, m_axis_tvalid)
  // One byte never causes more results than the window can hold
  `SSR_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, bq_n_q <= CNT_W'(PATTERN_MAX))

endmodule
